[hdl/microwire_eeprom_master_macros.svh]
// Assertion macros used by the sequencer module of the serial EEPROM master.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef MICROWIRE_EEPROM_MASTER_MACROS_SVH
`define MICROWIRE_EEPROM_MASTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MWE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MWE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/mwe_pkg.sv]
`timescale 1ns / 1ps

package mwe_pkg;

	localparam int ADDR_BITS = 11;
	localparam int DATA_BITS = 8;
	// Start bit plus opcode plus address: 1 + 2 + ADDR_BITS or 1 + 4 + (ADDR_BITS - 2).
	localparam int CMD_BITS = 3 + ADDR_BITS;
	localparam int FRAME_BITS = CMD_BITS + DATA_BITS;
	localparam int SEND_CW = $clog2(FRAME_BITS + 1);
	localparam int RECV_CW = $clog2(DATA_BITS + 1);
	localparam int POLL_W = 16;
	localparam logic [POLL_W-1:0] POLL_LIMIT_RST = 16'd5000;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 16;

	typedef enum logic [2:0] {
		OP_READ       = 3'd0,
		OP_EWEN       = 3'd1,
		OP_BYTE_ERASE = 3'd2,
		OP_ERAL       = 3'd3,
		OP_BYTE_WRITE = 3'd4,
		OP_WRAL       = 3'd5,
		OP_EWDS       = 3'd6
	} op_t;

	localparam logic [1:0] OPC_READ  = 2'b10;
	localparam logic [1:0] OPC_ERASE = 2'b11;
	localparam logic [1:0] OPC_WRITE = 2'b01;
	localparam logic [3:0] OPC_EWEN  = 4'b0011;
	localparam logic [3:0] OPC_ERAL  = 4'b0010;
	localparam logic [3:0] OPC_WRAL  = 4'b0001;
	localparam logic [3:0] OPC_EWDS  = 4'b0000;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_SEND = 3'd1,
		PH_RECV = 3'd2,
		PH_POLL = 3'd3,
		PH_END  = 3'd4
	} phase_t;

	typedef struct packed {
		logic        req_type;
		logic [2:0]  op;
		logic [10:0] address;
		logic [7:0]  write_data;
		logic        do_level;
	} item_t;

	typedef struct packed {
		logic       chip_select;
		logic       data_in_level;
		logic       clock_pulse;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte;
		logic       timed_out;
		logic       request_rejected;
	} res_t;

	// Start bit, opcode and address, MSB first.
	function automatic logic [CMD_BITS-1:0] cmd_word(input logic [2:0] op,
			input logic [10:0] address);
		logic [15:0] a;
		logic [CMD_BITS-1:0] w;
		a = 16'(address);
		case (op)
			OP_READ:       w = {1'b1, OPC_READ,  a[ADDR_BITS-1:0]};
			OP_BYTE_ERASE: w = {1'b1, OPC_ERASE, a[ADDR_BITS-1:0]};
			OP_BYTE_WRITE: w = {1'b1, OPC_WRITE, a[ADDR_BITS-1:0]};
			OP_EWEN:       w = {1'b1, OPC_EWEN,  a[ADDR_BITS-3:0]};
			OP_ERAL:       w = {1'b1, OPC_ERAL,  a[ADDR_BITS-3:0]};
			OP_WRAL:       w = {1'b1, OPC_WRAL,  a[ADDR_BITS-3:0]};
			default:       w = {1'b1, OPC_EWDS,  a[ADDR_BITS-3:0]};
		endcase
		return w;
	endfunction

	function automatic logic op_has_data(input logic [2:0] op);
		return (op == OP_BYTE_WRITE) || (op == OP_WRAL);
	endfunction

	function automatic logic op_needs_ready(input logic [2:0] op);
		return (op == OP_BYTE_ERASE) || (op == OP_ERAL) || (op == OP_BYTE_WRITE) ||
			(op == OP_WRAL);
	endfunction

endpackage

[hdl/mwe_seq.sv]
`timescale 1ns / 1ps
`include "microwire_eeprom_master_macros.svh"

module mwe_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            fire,
	input  mwe_pkg::item_t                  item,
	input  logic [mwe_pkg::POLL_W-1:0]      poll_limit,
	output mwe_pkg::res_t                   res
);
	import mwe_pkg::*;

	phase_t                phase_q, phase_d;
	logic [FRAME_BITS-1:0] shift_q, shift_d;
	logic [SEND_CW-1:0]    send_cnt_q, send_cnt_d;
	logic [RECV_CW-1:0]    recv_cnt_q, recv_cnt_d;
	logic [DATA_BITS-1:0]  in_shift_q, in_shift_d;
	logic [POLL_W-1:0]     poll_cnt_q, poll_cnt_d;
	logic                  wait_q, wait_d;
	logic                  to_q, to_d;
	logic                  op_bad;
	logic [POLL_W-1:0]     poll_inc;
	logic                  poll_expired;

	assign op_bad       = item.op > 3'(OP_EWDS);
	assign poll_inc     = poll_cnt_q + POLL_W'(1);
	assign poll_expired = poll_inc >= poll_limit;

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (fire) begin
			if (!item.req_type) begin
				if (phase_q == PH_IDLE && !op_bad) begin
					phase_d = PH_SEND;
				end
			end else begin
				unique case (phase_q)
					PH_SEND: begin
						if (send_cnt_q == SEND_CW'(1)) begin
							if (recv_cnt_q != '0) phase_d = PH_RECV;
							else if (wait_q)      phase_d = PH_POLL;
							else                  phase_d = PH_END;
						end
					end
					PH_RECV: begin
						if (recv_cnt_q == RECV_CW'(1)) begin
							phase_d = wait_q ? PH_POLL : PH_END;
						end
					end
					PH_POLL: begin
						if (item.do_level || poll_expired) phase_d = PH_END;
					end
					PH_END:  phase_d = PH_IDLE;
					default: phase_d = PH_IDLE;
				endcase
			end
		end
	end

	// Result word and datapath updates.
	always_comb begin
		res        = '0;
		shift_d    = shift_q;
		send_cnt_d = send_cnt_q;
		recv_cnt_d = recv_cnt_q;
		in_shift_d = in_shift_q;
		poll_cnt_d = poll_cnt_q;
		wait_d     = wait_q;
		to_d       = to_q;
		if (fire) begin
			if (!item.req_type) begin
				if (phase_q != PH_IDLE || op_bad) begin
					res.request_rejected = 1'b1;
					res.chip_select = (phase_q == PH_SEND) || (phase_q == PH_RECV) ||
						(phase_q == PH_POLL);
				end else begin
					shift_d = {cmd_word(item.op, item.address),
						op_has_data(item.op) ? DATA_BITS'(item.write_data) : DATA_BITS'(0)};
					send_cnt_d = op_has_data(item.op) ? SEND_CW'(FRAME_BITS) : SEND_CW'(CMD_BITS);
					recv_cnt_d = (item.op == OP_READ) ? RECV_CW'(DATA_BITS) : RECV_CW'(0);
					wait_d     = op_needs_ready(item.op);
					in_shift_d = '0;
					poll_cnt_d = '0;
					to_d       = 1'b0;
				end
			end else begin
				unique case (phase_q)
					PH_SEND: begin
						res.chip_select   = 1'b1;
						res.clock_pulse   = 1'b1;
						res.data_in_level = shift_q[FRAME_BITS-1];
						shift_d    = {shift_q[FRAME_BITS-2:0], 1'b0};
						send_cnt_d = send_cnt_q - SEND_CW'(1);
					end
					PH_RECV: begin
						res.chip_select = 1'b1;
						res.clock_pulse = 1'b1;
						in_shift_d = {in_shift_q[DATA_BITS-2:0], item.do_level};
						recv_cnt_d = recv_cnt_q - RECV_CW'(1);
					end
					PH_POLL: begin
						res.chip_select = 1'b1;
						if (!item.do_level) begin
							poll_cnt_d = poll_inc;
							if (poll_expired) to_d = 1'b1;
						end
					end
					PH_END: begin
						res.done_res  = 1'b1;
						res.read_byte = in_shift_q[7:0];
						res.timed_out = to_q;
						shift_d    = '0;
						send_cnt_d = '0;
						recv_cnt_d = '0;
						poll_cnt_d = '0;
						wait_d     = 1'b0;
						to_d       = 1'b0;
					end
					default: ;
				endcase
			end
		end
		res.busy_res = fire && (phase_d != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			shift_q    <= '0;
			send_cnt_q <= '0;
			recv_cnt_q <= '0;
			in_shift_q <= '0;
			poll_cnt_q <= '0;
			wait_q     <= 1'b0;
			to_q       <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			shift_q    <= shift_d;
			send_cnt_q <= send_cnt_d;
			recv_cnt_q <= recv_cnt_d;
			in_shift_q <= in_shift_d;
			poll_cnt_q <= poll_cnt_d;
			wait_q     <= wait_d;
			to_q       <= to_d;
		end
	end

	`MWE_ASSERT_NEXT(a_req_starts_send,
		fire && !item.req_type && phase_q == PH_IDLE && !op_bad, phase_q == PH_SEND,
		"accepted request did not enter the send phase")
	`MWE_ASSERT_SAME(a_done_releases,
		fire && res.done_res, !res.busy_res && !res.chip_select && !res.clock_pulse,
		"done word still shows select or busy")
	`MWE_ASSERT_SAME(a_poll_no_clock,
		fire && item.req_type && phase_q == PH_POLL, res.chip_select && !res.clock_pulse,
		"ready poll tick must hold select without clocking")
	`MWE_ASSERT_SAME(a_recv_count_live,
		phase_q == PH_RECV, recv_cnt_q != '0,
		"receive phase entered with an empty bit count")

endmodule

[hdl/microwire_eeprom_master.sv]
`timescale 1ns / 1ps
// Channel  | Direction | Content (lowest bits first)
// s_axis   | in        | tuser: req_type; tdata: op, address, write_data, do_level
// m_axis   | out       | tdata: chip_select, data_in_level, clock_pulse, busy_res,
//          |           |        done_res, read_byte, timed_out, request_rejected
// cfg      | in        | ready_poll_limit, written when cfg_we is high
//
// Each word passes from input to output through the input register and then through
// the sequencer into the result register. A new word is accepted in every cycle
// while the output side keeps taking results.
// Reset puts the sequencer into its idle phase and the poll limit to 5000 ticks.
// A stalled output holds the result register. With stage one full, s_tready drops in
// the same cycle; with stage one empty, one more word is taken before the input stalls.

module microwire_eeprom_master (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// op [2:0], address [13:3], write_data [21:14], do_level [22], zero [23]
	input  logic [mwe_pkg::S_TDATA_W-1:0]     s_tdata,
	// req_type [0]
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// chip_select [0], data_in_level [1], clock_pulse [2], busy_res [3], done_res [4],
	// read_byte [12:5], timed_out [13], request_rejected [14], zero [15]
	output logic [mwe_pkg::M_TDATA_W-1:0]     m_tdata,
	input  logic                              cfg_we,
	input  logic [mwe_pkg::POLL_W-1:0]        cfg_wdata
);
	import mwe_pkg::*;

	logic              valid_s1;
	item_t             item_s1;
	res_t              res_s2;
	res_t              res_now;
	logic              advance;
	logic              fire;
	logic [POLL_W-1:0] limit_q;

	// The result register can load when it is empty or being drained.
	assign advance  = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= POLL_LIMIT_RST;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (advance)  m_tvalid <= valid_s1;
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.req_type   <= s_tuser;
			item_s1.op         <= s_tdata[2:0];
			item_s1.address    <= s_tdata[13:3];
			item_s1.write_data <= s_tdata[21:14];
			item_s1.do_level   <= s_tdata[22];
		end
		if (fire) res_s2 <= res_now;
	end

	// The sequencer updates its state only on the cycle the word leaves stage one.
	mwe_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.item       (item_s1),
		.poll_limit (limit_q),
		.res        (res_now)
	);

	assign m_tdata = {1'b0, res_s2.request_rejected, res_s2.timed_out, res_s2.read_byte,
		res_s2.done_res, res_s2.busy_res, res_s2.clock_pulse, res_s2.data_in_level,
		res_s2.chip_select};

endmodule
